// ===== sv/odq_pkg.sv =====
// ----------------------------------------------------------------------------
// odq_pkg
// Shared constants, command and status codes, and the request and result
// types of the ordered list deque.
// ----------------------------------------------------------------------------
package odq_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int CMD_W = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int POS_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FIND       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_COUNT      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LIST       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd8;

  localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
  localparam logic [ST_W-1:0] ST_LISTED   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_WRONG    = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] operand_value;
  } odq_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        entry_count;
    logic                    last_result;
  } odq_rsp_t;

endpackage

// ===== sv/odq_if.sv =====
// ----------------------------------------------------------------------------
// odq_if
// Valid/ready channels for requests and results of the ordered list deque.
// ----------------------------------------------------------------------------
interface odq_cmd_if;
  logic               valid;
  logic               ready;
  odq_pkg::odq_cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface odq_rsp_if;
  logic               valid;
  logic               ready;
  odq_pkg::odq_rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ordered_list_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// ordered_list_deque_with_search
// Bounded list of signed 32-bit values in a circular buffer memory, with a
// small sequencer that scans, shifts and lists one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
// channel  | dir | handshake     | payload
// cmd_i    | in  | valid / ready | command, operand_value
// rsp_o    | out | valid / ready | status, entry_value, position,
//          |     |               | entry_count, last_result
//
// One request at a time. Find and delete scan from the front and stop at the
// first hit (or run over the whole count on a miss); delete then shifts the
// later entries forward through the memory's read and write ports. List
// returns one result per entry.
// Reset empties the list; the memory itself is not cleared.
// A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module ordered_list_deque_with_search (
  input  logic      clk_i,
  input  logic      rst_ni,
  odq_cmd_if.sink   cmd_i,
  odq_rsp_if.source rsp_o
);

  localparam int PTR_W = odq_pkg::PTR_W;
  localparam int CNT_W = odq_pkg::CNT_W;
  localparam int SUM_W = CNT_W + 1;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_SCAN     = 2'd2;
  localparam logic [1:0] S_SHIFT    = 2'd3;

  logic [1:0]                         state_q, state_d;
  logic [odq_pkg::CMD_W-1:0]          cmd_q;
  logic signed [odq_pkg::VAL_W-1:0]   val_q;
  logic [PTR_W-1:0]                   head_q, head_d;
  logic [CNT_W-1:0]                   count_q, count_d;
  logic [CNT_W-1:0]                   idx_q, idx_d;
  logic                               out_valid_q, out_valid_d;
  odq_pkg::odq_rsp_t                  out_data_q, rsp_d;

  logic signed [odq_pkg::VAL_W-1:0]   mem [odq_pkg::LIST_DEPTH];
  logic signed [odq_pkg::VAL_W-1:0]   rd_data_q;
  logic                               we, rd_en, emit;
  logic [PTR_W-1:0]                   wr_addr, rd_addr;
  logic signed [odq_pkg::VAL_W-1:0]   wr_data;

  logic                               out_free, hit, last;
  logic [CNT_W-1:0]                   idx_nxt;
  logic [PTR_W-1:0]                   head_inc, head_dec;

  function automatic logic [PTR_W-1:0] addr_of(logic [PTR_W-1:0] head,
                                                logic [CNT_W-1:0] i);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(i);
    if (sum >= SUM_W'(odq_pkg::LIST_DEPTH)) begin
      sum = sum - SUM_W'(odq_pkg::LIST_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign out_free = !out_valid_q || rsp_o.ready;
  assign hit      = (rd_data_q == val_q);
  assign idx_nxt  = idx_q + CNT_W'(1);
  assign last     = (idx_nxt == count_q);
  assign head_inc = (head_q == PTR_W'(odq_pkg::LIST_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign head_dec = (head_q == '0) ? PTR_W'(odq_pkg::LIST_DEPTH - 1) : head_q - PTR_W'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    we          = 1'b0;
    wr_addr     = '0;
    wr_data     = val_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    emit        = 1'b0;
    rsp_d       = '0;
    rsp_d.status      = odq_pkg::ST_DONE;
    rsp_d.last_result = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            odq_pkg::CMD_PUSH_FRONT, odq_pkg::CMD_PUSH_REAR: begin
              if (count_q == CNT_W'(odq_pkg::LIST_DEPTH)) begin
                rsp_d.status = odq_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (cmd_q == odq_pkg::CMD_PUSH_FRONT) begin
                  wr_addr = head_dec;
                  head_d  = head_dec;
                end else begin
                  wr_addr = addr_of(head_q, count_q);
                end
              end
            end
            odq_pkg::CMD_POP_FRONT, odq_pkg::CMD_POP_REAR: begin
              if (count_q == '0) begin
                rsp_d.status = odq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
                if (cmd_q == odq_pkg::CMD_POP_FRONT) begin
                  head_d = head_inc;
                end
              end
            end
            odq_pkg::CMD_DELETE, odq_pkg::CMD_FIND, odq_pkg::CMD_LIST: begin
              if (count_q == '0) begin
                rsp_d.status = (cmd_q == odq_pkg::CMD_LIST) ? odq_pkg::ST_EMPTY
                                                           : odq_pkg::ST_NOTFOUND;
              end else begin
                emit    = 1'b0;
                rd_en   = 1'b1;
                rd_addr = head_q;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            odq_pkg::CMD_COUNT: begin
              rsp_d.status = odq_pkg::ST_DONE;
            end
            odq_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
              rsp_d.status = odq_pkg::ST_WRONG;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(head_q, idx_nxt);
          idx_d   = idx_nxt;
          case (cmd_q)
            odq_pkg::CMD_FIND: begin
              if (hit) begin
                emit           = 1'b1;
                rsp_d.position = odq_pkg::POS_W'(idx_nxt);
                state_d        = S_IDLE;
              end else if (last) begin
                emit         = 1'b1;
                rsp_d.status = odq_pkg::ST_NOTFOUND;
                state_d      = S_IDLE;
              end
            end
            odq_pkg::CMD_DELETE: begin
              if (hit) begin
                state_d = S_SHIFT;
              end else if (last) begin
                emit         = 1'b1;
                rsp_d.status = odq_pkg::ST_NOTFOUND;
                state_d      = S_IDLE;
              end
            end
            default: begin
              emit              = 1'b1;
              rsp_d.status      = odq_pkg::ST_LISTED;
              rsp_d.entry_value = rd_data_q;
              rsp_d.position    = odq_pkg::POS_W'(idx_nxt);
              rsp_d.last_result = last;
              if (last) begin
                state_d = S_IDLE;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // idx_q is the logical slot whose data sits in rd_data_q
        if (idx_q == count_q) begin
          if (out_free) begin
            emit    = 1'b1;
            count_d = count_q - CNT_W'(1);
            state_d = S_IDLE;
          end
        end else begin
          we      = 1'b1;
          wr_addr = addr_of(head_q, idx_q - CNT_W'(1));
          wr_data = rd_data_q;
          rd_en   = 1'b1;
          rd_addr = addr_of(head_q, idx_nxt);
          idx_d   = idx_nxt;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.entry_count = odq_pkg::POS_W'(count_d);

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_i.valid) begin
      cmd_q <= cmd_i.data.command;
      val_q <= cmd_i.data.operand_value;
    end
    if (emit) begin
      out_data_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

// ===== sv/odq_checker.sv =====
// ----------------------------------------------------------------------------
// odq_checker
// Port-level checks of the ordered list deque, bound to the top level.
// ----------------------------------------------------------------------------
module odq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input odq_pkg::odq_rsp_t rsp_data_i
);

  // one request in flight: no accept on the cycle after an accept
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !cmd_ready_i)
    else $error("request accepted back to back");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_data_i)))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_data_i.status != odq_pkg::ST_LISTED) |-> rsp_data_i.last_result)
    else $error("single status result not marked last");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_data_i.status == odq_pkg::ST_FULL)
      |-> (rsp_data_i.entry_count == odq_pkg::POS_W'(odq_pkg::LIST_DEPTH)))
    else $error("full reported below capacity");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_data_i.status != odq_pkg::ST_DONE
                 && rsp_data_i.status != odq_pkg::ST_LISTED)
      |-> (rsp_data_i.position == '0 && rsp_data_i.entry_value == '0))
    else $error("position or value set on a failing status");

endmodule

bind ordered_list_deque_with_search odq_checker u_odq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
